[hdl/ita_pkg.sv]
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and character tables of the integer to ascii
// formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

   // command codes
   localparam logic [1:0] CMD_DEC       = 2'd0;
   localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
   localparam logic [1:0] CMD_HEX_UPPER = 2'd2;
   localparam logic [1:0] CMD_POINTER   = 2'd3;

   // digit register geometry
   localparam int NumDigits    = 20;
   localparam int DigitRegBits = 4 * NumDigits;
   localparam int ValueBits    = 64;
   localparam int DabbleSteps  = ValueBits;

   typedef logic [3:0] digit_type;
   typedef logic [7:0] char_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_PREFIX,
      ST_SKIP,
      ST_DIGITS
   } state_type;

   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_MINUS,
      PFX_HEX,
      PFX_NIL
   } prefix_type;

   // operations requested from the digit unit
   typedef struct packed {
      logic load_dec;
      logic load_hex;
      logic step;
      logic shift;
   } unit_ctl_type;

   // digit value to ascii
   function automatic char_type digit_char(input digit_type d, input logic upper);
      char_type c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else if (upper) begin
         c = 8'h41 + {4'd0, d - 4'd10};
      end else begin
         c = 8'h61 + {4'd0, d - 4'd10};
      end
      return c;
   endfunction

   // index of the final prefix character
   function automatic logic [2:0] prefix_last_idx(input prefix_type kind);
      logic [2:0] n;
      unique case (kind)
         PFX_HEX: n = 3'd1;
         PFX_NIL: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // prefix characters: "-", "0x", "(nil)"
   function automatic char_type prefix_char(input prefix_type kind, input logic [2:0] idx);
      char_type c;
      unique case (kind)
         PFX_MINUS: c = 8'h2d;
         PFX_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78;
         PFX_NIL: begin
            unique case (idx)
               3'd0:    c = 8'h28;
               3'd1:    c = 8'h6e;
               3'd2:    c = 8'h69;
               3'd3:    c = 8'h6c;
               default: c = 8'h29;
            endcase
         end
         default:   c = 8'h30;
      endcase
      return c;
   endfunction

endpackage

[hdl/ita_if.sv]
// ----------------------------------------------------------------------------
// ita interfaces
// Valid/ready channels for formatter requests and character responses.
// ----------------------------------------------------------------------------

// request channel: command and operand
interface ita_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// response channel: one character per transaction
interface ita_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

[hdl/integer_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 64-bit operand as signed decimal, hex or pointer ascii text.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_if.ready is high only while idle, and
// a request is taken in an idle cycle. Decimal requests then run through the
// shared double-dabble shift unit (one operand bit per cycle); hex and
// pointer requests load their nibbles in the accept cycle itself. The 20-digit
// register then skips leading zeros (one digit per cycle) and emits the
// remaining digits (one per cycle while the sink takes them). A sign or
// prefix character goes out ahead of the digits, and a nil pointer gives
// its prefix text alone. The final character of each text carries last.
module integer_to_ascii_formatter_top #(
   parameter int PTR_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ita_req_if.sink     req_if,
   ita_rsp_if.source   rsp_if
);

   ita_pkg::unit_ctl_type unit_ctl;
   ita_pkg::digit_type    top_digit;
   logic                  ptr_zero;

   // shared conversion unit
   ita_digit_unit #(
      .PTR_DIGITS (PTR_DIGITS)
   ) u_digit_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (unit_ctl),
      .load_cmd   (req_if.cmd),
      .load_value (req_if.value),
      .top_digit  (top_digit),
      .ptr_zero   (ptr_zero)
   );

   // sequencer and response stage
   ita_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_sign  (req_if.value[63]),
      .ptr_zero  (ptr_zero),
      .top_digit (top_digit),
      .req_ready (req_if.ready),
      .unit_ctl  (unit_ctl),
      .rsp_valid (rsp_if.valid),
      .rsp_char  (rsp_if.char_out),
      .rsp_last  (rsp_if.last),
      .rsp_ready (rsp_if.ready)
   );

endmodule

[hdl/ita_digit_unit.sv]
// ----------------------------------------------------------------------------
// ita_digit_unit
// Shared shift unit: double-dabble binary to bcd conversion one bit per
// cycle, direct nibble load for hex, and digit shift-out from the top.
// ----------------------------------------------------------------------------
module ita_digit_unit #(
   parameter int PTR_DIGITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ita_pkg::unit_ctl_type  ctl,
   input  logic [1:0]             load_cmd,
   input  logic [63:0]            load_value,
   output ita_pkg::digit_type     top_digit,
   output logic                   ptr_zero
);

   localparam int PtrBits = 4 * PTR_DIGITS;
   localparam logic [63:0] PtrMask = {64{1'b1}} >> (64 - PtrBits);

   logic [ita_pkg::ValueBits-1:0]    work_ff, work_in;
   logic [ita_pkg::DigitRegBits-1:0] digits_ff, digits_in;
   logic [ita_pkg::DigitRegBits-1:0] adjusted;
   logic [63:0]                      magnitude;
   logic [63:0]                      hex_value;

   // operand forms for loading
   assign magnitude = load_value[63] ? (64'd0 - load_value) : load_value;
   assign hex_value = (load_cmd == ita_pkg::CMD_POINTER) ? (load_value & PtrMask)
                                                         : {32'd0, load_value[31:0]};
   assign ptr_zero  = ((load_value & PtrMask) == 64'd0);

   // add three to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < ita_pkg::NumDigits; i++) begin
         adjusted[4*i +: 4] = (digits_ff[4*i +: 4] >= 4'd5) ? (digits_ff[4*i +: 4] + 4'd3)
                                                            : digits_ff[4*i +: 4];
      end
   end

   // next value of the working registers
   always_comb begin
      work_in   = work_ff;
      digits_in = digits_ff;
      priority if (ctl.load_dec) begin
         work_in   = magnitude;
         digits_in = '0;
      end else if (ctl.load_hex) begin
         digits_in = {16'd0, hex_value};
      end else if (ctl.step) begin
         work_in   = {work_ff[62:0], 1'b0};
         digits_in = {adjusted[ita_pkg::DigitRegBits-2:0], work_ff[63]};
      end else if (ctl.shift) begin
         digits_in = {digits_ff[ita_pkg::DigitRegBits-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
      end else begin
         work_ff <= work_in;
      end
      digits_ff <= digits_in;
   end

   assign top_digit = digits_ff[ita_pkg::DigitRegBits-1 -: 4];

endmodule

[hdl/ita_ctrl.sv]
// ----------------------------------------------------------------------------
// ita_ctrl
// Sequencer: runs the conversion, emits prefix, skips leading zeros and
// emits digits through a registered response stage.
// ----------------------------------------------------------------------------
module ita_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   input  logic                   req_sign,
   input  logic                   ptr_zero,
   input  ita_pkg::digit_type     top_digit,
   output logic                   req_ready,
   output ita_pkg::unit_ctl_type  unit_ctl,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_char,
   output logic                   rsp_last,
   input  logic                   rsp_ready
);

   ita_pkg::state_type  state_ff, state_in;
   ita_pkg::prefix_type kind_ff, kind_in;
   logic                upper_ff, upper_in;
   logic [2:0]          pfx_idx_ff, pfx_idx_in;
   logic [5:0]          iter_ff, iter_in;
   logic [4:0]          remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                accept;
   logic                out_free;
   logic                pfx_done;
   logic                skip_more;

   assign accept    = req_valid && (state_ff == ita_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pfx_done  = (pfx_idx_ff == ita_pkg::prefix_last_idx(kind_ff));
   assign skip_more = (top_digit == 4'd0) && (remain_ff > 5'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ita_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_cmd == ita_pkg::CMD_DEC) state_in = ita_pkg::ST_DABBLE;
               else if (req_cmd == ita_pkg::CMD_POINTER) state_in = ita_pkg::ST_PREFIX;
               else state_in = ita_pkg::ST_SKIP;
            end
         end
         ita_pkg::ST_DABBLE: begin
            if (iter_ff == 6'(ita_pkg::DabbleSteps - 1)) begin
               state_in = (kind_ff == ita_pkg::PFX_MINUS) ? ita_pkg::ST_PREFIX
                                                          : ita_pkg::ST_SKIP;
            end
         end
         ita_pkg::ST_PREFIX: begin
            if (out_free && pfx_done) begin
               state_in = (kind_ff == ita_pkg::PFX_NIL) ? ita_pkg::ST_IDLE
                                                        : ita_pkg::ST_SKIP;
            end
         end
         ita_pkg::ST_SKIP: begin
            if (!skip_more) state_in = ita_pkg::ST_DIGITS;
         end
         ita_pkg::ST_DIGITS: begin
            if (out_free && (remain_ff == 5'd1)) state_in = ita_pkg::ST_IDLE;
         end
         default: state_in = ita_pkg::ST_IDLE;
      endcase
   end

   // datapath controls and register updates
   always_comb begin
      kind_in      = kind_ff;
      upper_in     = upper_ff;
      pfx_idx_in   = pfx_idx_ff;
      iter_in      = iter_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unit_ctl     = '0;
      unique case (state_ff)
         ita_pkg::ST_IDLE: begin
            if (accept) begin
               pfx_idx_in = 3'd0;
               iter_in    = 6'd0;
               remain_in  = 5'(ita_pkg::NumDigits);
               upper_in   = (req_cmd == ita_pkg::CMD_HEX_UPPER);
               priority if (req_cmd == ita_pkg::CMD_DEC) begin
                  kind_in           = req_sign ? ita_pkg::PFX_MINUS : ita_pkg::PFX_NONE;
                  unit_ctl.load_dec = 1'b1;
               end else if (req_cmd == ita_pkg::CMD_POINTER) begin
                  kind_in           = ptr_zero ? ita_pkg::PFX_NIL : ita_pkg::PFX_HEX;
                  unit_ctl.load_hex = 1'b1;
               end else begin
                  kind_in           = ita_pkg::PFX_NONE;
                  unit_ctl.load_hex = 1'b1;
               end
            end
         end
         ita_pkg::ST_DABBLE: begin
            unit_ctl.step = 1'b1;
            iter_in       = iter_ff + 6'd1;
         end
         ita_pkg::ST_PREFIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ita_pkg::prefix_char(kind_ff, pfx_idx_ff);
               rsp_last_in  = pfx_done && (kind_ff == ita_pkg::PFX_NIL);
               pfx_idx_in   = pfx_idx_ff + 3'd1;
            end
         end
         ita_pkg::ST_SKIP: begin
            if (skip_more) begin
               unit_ctl.shift = 1'b1;
               remain_in      = remain_ff - 5'd1;
            end
         end
         ita_pkg::ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_char_in    = ita_pkg::digit_char(top_digit, upper_ff);
               rsp_last_in    = (remain_ff == 5'd1);
               unit_ctl.shift = 1'b1;
               remain_in      = remain_ff - 5'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ita_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
         iter_ff      <= iter_in;
      end
      kind_ff     <= kind_in;
      upper_ff    <= upper_in;
      pfx_idx_ff  <= pfx_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready = (state_ff == ita_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

   // accepted transaction always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ita_pkg::ST_IDLE)
      else $error("idle right after accepting a transaction");

   // digit phases always have a digit left
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ita_pkg::ST_SKIP || state_ff == ita_pkg::ST_DIGITS) |-> remain_ff != 5'd0)
      else $error("digit phase with no digits left");

   // conversion counter advances by one each cycle
   a_dabble_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ita_pkg::ST_DABBLE && iter_ff != 6'(ita_pkg::DabbleSteps - 1))
      |=> (state_ff == ita_pkg::ST_DABBLE && iter_ff == $past(iter_ff) + 6'd1))
      else $error("conversion counter skipped");

   // leaving the digit phase puts the final character in the output stage
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ita_pkg::ST_DIGITS && state_ff == ita_pkg::ST_IDLE)
      |-> (rsp_valid_ff && rsp_last_ff))
      else $error("text ended without a final character");

endmodule

[tb/tb_integer_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top
// Self-checking bench for the integer to ascii formatter. Requests are sent
// with random gaps and responses are taken with random stalls. Each accepted
// request is formatted in the bench: signed decimal, hex lower, hex upper or
// pointer text. Every response character and its last flag is compared with
// the oldest expected character.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_top;

   localparam int PTR_DIGITS     = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int RANDOM_ITEMS   = 330;
   localparam int QUIET_ITEMS    = 50;

   // expected text of accepted requests, oldest character first
   class ascii_text_scoreboard;
      logic [7:0] expected_chars[$];
      logic       expected_last[$];
      int         error_count;

      // format one accepted request and queue its characters
      function void note_request(input logic [1:0] cmd, input logic [63:0] value);
         logic [7:0]  text[$];
         logic [3:0]  digits[$];
         logic [63:0] magnitude;
         logic [63:0] ptr_mask;
         logic [63:0] radix;
         logic        upper;
         string       nil_text;
         nil_text  = "(nil)";
         upper     = 1'b0;
         radix     = 64'd16;
         ptr_mask  = (PTR_DIGITS == 16) ? '1 : ((64'd1 << (4 * PTR_DIGITS)) - 64'd1);
         magnitude = 64'd0;
         unique case (cmd)
            ita_pkg::CMD_DEC: begin
               radix = 64'd10;
               // most negative operand: unsigned negation keeps the magnitude
               if (value[63]) begin
                  text.push_back("-");
                  magnitude = -value;
               end else begin
                  magnitude = value;
               end
            end
            ita_pkg::CMD_HEX_LOWER: magnitude = {32'd0, value[31:0]};
            ita_pkg::CMD_HEX_UPPER: begin
               magnitude = {32'd0, value[31:0]};
               upper     = 1'b1;
            end
            default: begin
               magnitude = value & ptr_mask;
               if (magnitude == 64'd0) begin
                  for (int i = 0; i < 5; i++) text.push_back(nil_text[i]);
               end else begin
                  text.push_back("0");
                  text.push_back("x");
               end
            end
         endcase
         // digits, most significant first, no leading zeros
         if (!(cmd == ita_pkg::CMD_POINTER && magnitude == 64'd0)) begin
            do begin
               digits.push_front(4'(magnitude % radix));
               magnitude = magnitude / radix;
            end while (magnitude != 64'd0);
         end
         foreach (digits[i]) begin
            if (digits[i] < 4'd10) begin
               text.push_back(8'h30 + digits[i]);
            end else begin
               text.push_back((upper ? 8'h41 : 8'h61) + digits[i] - 8'd10);
            end
         end
         foreach (text[i]) begin
            expected_chars.push_back(text[i]);
            expected_last.push_back(i == text.size() - 1);
         end
      endfunction

      // compare one response transaction with the oldest expectation
      function void check_char(input logic [7:0] char_out, input logic last);
         logic [7:0] exp_char;
         logic       exp_last;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none actual %h last %b",
                     $time, char_out, last);
            error_count++;
            return;
         end
         exp_char = expected_chars.pop_front();
         exp_last = expected_last.pop_front();
         if (char_out !== exp_char) begin
            $display("%0t: char_out mismatch, expected %h actual %h", $time, exp_char,
                     char_out);
            error_count++;
         end
         if (last !== exp_last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, exp_last, last);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet_phase;
   int   idle_cycles = 0;

   ascii_text_scoreboard text_sb;

   ita_req_if req_if ();
   ita_rsp_if rsp_if ();

   integer_to_ascii_formatter_top #(
      .PTR_DIGITS(PTR_DIGITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // clock
   always #5 clock = ~clock;

   // drive one request, waiting for its handshake
   task automatic send_request(input logic [1:0] cmd, input logic [63:0] value);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= cmd;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
      text_sb.note_request(cmd, value);
   endtask

   // response side stalls in bursts, none during the quiet phase
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20) - 1) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         text_sb.check_char(rsp_if.char_out, rsp_if.last);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin
      logic [1:0]  cmd;
      logic [63:0] value;
      int          width;
      text_sb      = new;
      quiet_phase  = 1'b0;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd   <= ita_pkg::CMD_DEC;
      req_if.value <= 64'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: decimal extremes, zero, sign and most negative value
      send_request(ita_pkg::CMD_DEC, 64'd0);
      send_request(ita_pkg::CMD_DEC, 64'd1);
      send_request(ita_pkg::CMD_DEC, '1);
      send_request(ita_pkg::CMD_DEC, 64'd9);
      send_request(ita_pkg::CMD_DEC, 64'd10);
      send_request(ita_pkg::CMD_DEC, 64'h7fff_ffff_ffff_ffff);
      send_request(ita_pkg::CMD_DEC, 64'h8000_0000_0000_0000);
      send_request(ita_pkg::CMD_DEC, 64'd1234567890);
      send_request(ita_pkg::CMD_DEC, -64'd1234567890);
      // directed: hex keeps only the low word
      send_request(ita_pkg::CMD_HEX_LOWER, 64'd0);
      send_request(ita_pkg::CMD_HEX_LOWER, 64'hffff_ffff);
      send_request(ita_pkg::CMD_HEX_LOWER, 64'h1234_5678_9abc_def0);
      send_request(ita_pkg::CMD_HEX_LOWER, 64'h10);
      send_request(ita_pkg::CMD_HEX_UPPER, 64'h00ab_cdef);
      send_request(ita_pkg::CMD_HEX_UPPER, 64'hffff_ffff_0000_0000);
      send_request(ita_pkg::CMD_HEX_UPPER, 64'ha);
      // directed: pointer, nil and full width
      send_request(ita_pkg::CMD_POINTER, 64'd0);
      send_request(ita_pkg::CMD_POINTER, 64'd1);
      send_request(ita_pkg::CMD_POINTER, '1);
      send_request(ita_pkg::CMD_POINTER, 64'h8000_0000_0000_0000);
      send_request(ita_pkg::CMD_POINTER, 64'h0000_7fff_ffff_f000);

      // random: operand widths spread so short and long texts both occur
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
         cmd   = 2'($urandom_range(0, 3));
         width = $urandom_range(1, 64);
         value = {$urandom, $urandom};
         if (width < 64) value &= (64'd1 << width) - 64'd1;
         if (cmd == ita_pkg::CMD_DEC && $urandom_range(0, 1) == 1) value = -value;
         case ($urandom_range(0, 19))
            0: value = 64'd0;
            1: value = 64'h8000_0000_0000_0000;
            2: value = '1;
            default: ;
         endcase
         send_request(cmd, value);
      end
      req_if.valid <= 1'b0;

      // drain
      while (text_sb.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (text_sb.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
